@@ rtl/ple_pkg.sv @@
// Package for the positional list engine: operation and status codes,
// field widths and the item structs of the request and response channels.
// No dependencies.
`timescale 1ns / 1ps

package ple_pkg;

	localparam int FuncW   = 2;
	localparam int ValueW  = 32;
	localparam int PosW    = 7;
	localparam int LenW    = 7;
	localparam int StatusW = 2;

	localparam logic [FuncW-1:0] FUNC_APPEND = 2'd0;
	localparam logic [FuncW-1:0] FUNC_INSERT = 2'd1;
	localparam logic [FuncW-1:0] FUNC_REMOVE = 2'd2;
	localparam logic [FuncW-1:0] FUNC_READ   = 2'd3;

	localparam logic [StatusW-1:0] STATUS_OK    = 2'd0;
	localparam logic [StatusW-1:0] STATUS_RANGE = 2'd1;
	localparam logic [StatusW-1:0] STATUS_FULL  = 2'd2;

	typedef struct packed {
		logic [FuncW-1:0]  func;
		logic [ValueW-1:0] value;
		logic [PosW-1:0]   position;
	} req_item_t;

	typedef struct packed {
		logic [ValueW-1:0]  read_value;
		logic [LenW-1:0]    length;
		logic               empty_res;
		logic [StatusW-1:0] status;
	} rsp_item_t;

endpackage

@@ rtl/ple_chan_if.sv @@
// Valid/ready channel carrying one item of type T per handshake.
// Used with ple_pkg::req_item_t and ple_pkg::rsp_item_t.
`timescale 1ns / 1ps

interface ple_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/positional_list_engine.sv @@
// Positional list engine: ordered list of up to CAPACITY values held in a
// single synchronous RAM. Depends on ple_pkg and ple_chan_if.
`timescale 1ns / 1ps

// Usage:
//   req carries one operation per item (append, insert, remove, read with a
//   1-based position); rsp returns one item per request with the value read,
//   the new length, an empty flag and a status (ok, bad position, full).
//   Items are taken one at a time: req.ready is high only while no request
//   is in progress. Insert and remove move one element per cycle through
//   the RAM (one read and one write port). A finished response sits in an
//   output register; if rsp.ready is low, the engine holds the next finished
//   response until that register frees, while req stays stalled. Reset
//   empties the list; RAM contents are not cleared, as only entries below
//   the length are ever read.
module positional_list_engine
	import ple_pkg::*;
#(
	parameter int CAPACITY   = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	ple_chan_if.sink         req,
	ple_chan_if.source       rsp
);

	localparam int AW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW     = $clog2(CAPACITY + 1);
	localparam int PW     = (CW > PosW) ? CW : PosW;
	localparam int StoreW = (DATA_WIDTH < ValueW) ? DATA_WIDTH : ValueW;

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_SHIFT_UP = 3'd1;
	localparam logic [2:0] S_INS_FILL = 3'd2;
	localparam logic [2:0] S_SHIFT_DN = 3'd3;
	localparam logic [2:0] S_READ     = 3'd4;
	localparam logic [2:0] S_DONE     = 3'd5;

	logic [2:0]          state_q;
	logic [CW-1:0]       count_q;
	logic                out_valid_q;
	rsp_item_t           out_q;
	logic [AW-1:0]       ptr_q;
	logic [AW-1:0]       pidx_q;
	logic [StoreW-1:0]   val_q;
	logic [ValueW-1:0]   rd_q;
	logic [StatusW-1:0]  st_q;

	logic [StoreW-1:0]   mem_q [CAPACITY];
	logic [StoreW-1:0]   rdata_q;

	logic                acc;
	logic                full;
	logic                pos_ok;
	logic                pos_last;
	logic [PW-1:0]       pos_ext;
	logic [PW-1:0]       pos_m1;
	logic [AW-1:0]       pidx_in;
	logic [AW-1:0]       cm1;
	logic                load_out;

	logic                mem_we;
	logic [AW-1:0]       mem_waddr;
	logic [StoreW-1:0]   mem_wdata;
	logic                mem_re;
	logic [AW-1:0]       mem_raddr;

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	assign acc      = req.valid && req.ready;
	assign full     = (count_q == CW'(CAPACITY));
	assign pos_ext  = PW'(req.data.position);
	assign pos_m1   = pos_ext - PW'(1);
	assign pidx_in  = pos_m1[AW-1:0];
	assign cm1      = AW'(count_q - CW'(1));
	assign pos_ok   = (pos_ext != '0) && (pos_ext <= PW'(count_q));
	assign pos_last = (pos_ext == PW'(count_q));
	assign load_out = (state_q == S_DONE) && (!out_valid_q || rsp.ready);

	// RAM port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = rdata_q;
		mem_re    = 1'b0;
		mem_raddr = '0;
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					case (req.data.func)
						FUNC_APPEND: begin
							mem_we    = !full;
							mem_waddr = count_q[AW-1:0];
							mem_wdata = req.data.value[StoreW-1:0];
						end
						FUNC_INSERT: begin
							mem_re    = pos_ok && !full;
							mem_raddr = cm1;
						end
						FUNC_REMOVE: begin
							mem_re    = pos_ok && !pos_last;
							mem_raddr = AW'(pidx_in + AW'(1));
						end
						FUNC_READ: begin
							mem_re    = pos_ok;
							mem_raddr = pidx_in;
						end
						default: ;
					endcase
				end
			end
			S_SHIFT_UP: begin
				// element at ptr moves one place back; next read trails below
				mem_we    = 1'b1;
				mem_waddr = AW'(ptr_q + AW'(1));
				mem_re    = (ptr_q != pidx_q);
				mem_raddr = AW'(ptr_q - AW'(1));
			end
			S_INS_FILL: begin
				mem_we    = 1'b1;
				mem_waddr = pidx_q;
				mem_wdata = val_q;
			end
			S_SHIFT_DN: begin
				mem_we    = 1'b1;
				mem_waddr = AW'(ptr_q - AW'(1));
				mem_re    = (ptr_q != cm1);
				mem_raddr = AW'(ptr_q + AW'(1));
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem_q[mem_raddr];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						state_q <= S_DONE;
						case (req.data.func)
							FUNC_APPEND: begin
								if (!full) count_q <= count_q + CW'(1);
							end
							FUNC_INSERT: begin
								if (pos_ok && !full) state_q <= S_SHIFT_UP;
							end
							FUNC_REMOVE: begin
								if (pos_ok && pos_last) count_q <= count_q - CW'(1);
								else if (pos_ok) state_q <= S_SHIFT_DN;
							end
							FUNC_READ: begin
								if (pos_ok) state_q <= S_READ;
							end
							default: ;
						endcase
					end
				end
				S_SHIFT_UP: begin
					if (ptr_q == pidx_q) state_q <= S_INS_FILL;
				end
				S_INS_FILL: begin
					count_q <= count_q + CW'(1);
					state_q <= S_DONE;
				end
				S_SHIFT_DN: begin
					if (ptr_q == cm1) begin
						count_q <= count_q - CW'(1);
						state_q <= S_DONE;
					end
				end
				S_READ: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (load_out) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					val_q  <= req.data.value[StoreW-1:0];
					pidx_q <= pidx_in;
					rd_q   <= '0;
					st_q   <= STATUS_OK;
					case (req.data.func)
						FUNC_APPEND: begin
							if (full) st_q <= STATUS_FULL;
						end
						FUNC_INSERT: begin
							ptr_q <= cm1;
							if (!pos_ok) st_q <= STATUS_RANGE;
							else if (full) st_q <= STATUS_FULL;
						end
						FUNC_REMOVE: begin
							ptr_q <= AW'(pidx_in + AW'(1));
							if (!pos_ok) st_q <= STATUS_RANGE;
						end
						FUNC_READ: begin
							if (!pos_ok) st_q <= STATUS_RANGE;
						end
						default: ;
					endcase
				end
			end
			S_SHIFT_UP: begin
				if (ptr_q != pidx_q) ptr_q <= AW'(ptr_q - AW'(1));
			end
			S_SHIFT_DN: begin
				ptr_q <= AW'(ptr_q + AW'(1));
			end
			S_READ: begin
				rd_q <= ValueW'(rdata_q);
			end
			S_DONE: begin
				if (load_out) begin
					out_q.read_value <= rd_q;
					out_q.length     <= LenW'(count_q);
					out_q.empty_res  <= (count_q == '0);
					out_q.status     <= st_q;
				end
			end
			default: ;
		endcase
	end

	// the list never grows past its capacity
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("element count above capacity");

	// every RAM read targets a live element
	a_read_live: assert property (@(posedge clk) disable iff (!arst_n)
		mem_re |-> (CW'(mem_raddr) < count_q))
		else $error("RAM read beyond list length");

	// insert walk stays at or above the target slot, below the tail
	a_shift_up: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT_UP) |-> ((ptr_q >= pidx_q) && (CW'(ptr_q) < count_q)))
		else $error("insert walk out of bounds");

	// remove walk never passes the last element
	a_shift_dn: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT_DN) |-> ((ptr_q != '0) && (CW'(ptr_q) < count_q)))
		else $error("remove walk out of bounds");

	// a response waiting on a stalled receiver is not overwritten
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !rsp.ready) |=> (out_valid_q && $stable(out_q)))
		else $error("pending response overwritten");

endmodule

@@ tb/tb.sv @@
// Testbench for positional_list_engine: directed and random list operations,
// each response checked against a behavioral list kept in the testbench.
// Depends on ple_pkg, ple_chan_if and positional_list_engine.
`timescale 1ns / 1ps

module tb;
	import ple_pkg::*;

	localparam int CAP      = 64;
	localparam int DATA_W   = 32;
	localparam int N_RANDOM = 550;

	logic      clk    = 1'b0;
	logic      arst_n = 1'b0;
	logic      src_valid = 1'b0;
	req_item_t src_item  = '0;
	logic      sink_rdy  = 1'b0;

	int src_idle_pct  = 0;
	int sink_idle_pct = 0;
	int err_cnt   = 0;
	int n_sent    = 0;
	int n_checked = 0;
	int n_full    = 0;
	int n_range   = 0;
	int peak_len  = 0;

	// behavioral copy of the list
	logic [DATA_W-1:0] list_mem [CAP];
	int                list_len = 0;
	rsp_item_t         expected_rsps [$];

	ple_chan_if #(.T(req_item_t)) req_ch ();
	ple_chan_if #(.T(rsp_item_t)) rsp_ch ();

	assign req_ch.valid = src_valid;
	assign req_ch.data  = src_item;
	assign rsp_ch.ready = sink_rdy;

	positional_list_engine #(
		.CAPACITY   (CAP),
		.DATA_WIDTH (DATA_W)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #5 clk = ~clk;

	function automatic rsp_item_t apply_list_op(input req_item_t r);
		rsp_item_t o;
		logic      pos_ok;
		int        p;
		int        i;
		o = '0;
		o.status = STATUS_OK;
		p = int'(r.position);
		pos_ok = (p >= 1) && (p <= list_len);
		case (r.func)
			FUNC_APPEND: begin
				if (list_len >= CAP) begin
					o.status = STATUS_FULL;
				end else begin
					list_mem[list_len] = r.value;
					list_len++;
				end
			end
			FUNC_INSERT: begin
				if (!pos_ok) begin
					o.status = STATUS_RANGE;
				end else if (list_len >= CAP) begin
					o.status = STATUS_FULL;
				end else begin
					for (i = list_len; i > p - 1; i--)
						list_mem[i] = list_mem[i-1];
					list_mem[p-1] = r.value;
					list_len++;
				end
			end
			FUNC_REMOVE: begin
				if (!pos_ok) begin
					o.status = STATUS_RANGE;
				end else begin
					for (i = p - 1; i + 1 < list_len; i++)
						list_mem[i] = list_mem[i+1];
					list_len--;
				end
			end
			default: begin
				if (!pos_ok)
					o.status = STATUS_RANGE;
				else
					o.read_value = list_mem[p-1];
			end
		endcase
		o.length    = LenW'(list_len);
		o.empty_res = (list_len == 0);
		return o;
	endfunction

	// Sends one item; returns at the edge where it was accepted. Valid is
	// left high so a back-to-back item needs no second assignment.
	task automatic send_op(input logic [FuncW-1:0] f, input logic [ValueW-1:0] v,
			input logic [PosW-1:0] p);
		req_item_t item;
		rsp_item_t want;
		item.func     = f;
		item.value    = v;
		item.position = p;
		while ($urandom_range(99) < src_idle_pct) begin
			src_valid <= 1'b0;
			src_item  <= req_item_t'($urandom);
			@(posedge clk);
		end
		src_valid <= 1'b1;
		src_item  <= item;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		want = apply_list_op(item);
		if (want.status == STATUS_FULL)
			n_full++;
		if (want.status == STATUS_RANGE)
			n_range++;
		if (list_len > peak_len)
			peak_len = list_len;
		expected_rsps.push_back(want);
		n_sent++;
	endtask

	task automatic wait_idle();
		src_valid <= 1'b0;
		@(posedge clk);
		while (expected_rsps.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (!arst_n)
			sink_rdy <= 1'b0;
		else
			sink_rdy <= ($urandom_range(99) >= sink_idle_pct);
	end

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			err_cnt++;
		end
	endtask

	always @(posedge clk) begin : rsp_check
		rsp_item_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_rsps.size() == 0) begin
				$error("response item with no request outstanding");
				err_cnt++;
			end else begin
				want = expected_rsps.pop_front();
				check_field("read_value", want.read_value, rsp_ch.data.read_value);
				check_field("length", want.length, rsp_ch.data.length);
				check_field("empty_res", want.empty_res, rsp_ch.data.empty_res);
				check_field("status", want.status, rsp_ch.data.status);
				n_checked++;
			end
		end
	end

	// empty list, edge positions, both value extremes, shifts at head and tail
	task automatic test_directed_ops();
		send_op(FUNC_READ, 32'h0, 7'd1);
		send_op(FUNC_REMOVE, 32'h0, 7'd0);
		send_op(FUNC_INSERT, 32'hDEADBEEF, 7'd1);
		send_op(FUNC_APPEND, 32'h0000_0000, 7'd0);
		send_op(FUNC_APPEND, 32'hFFFF_FFFF, 7'd127);
		send_op(FUNC_INSERT, 32'hA5A5_A5A5, 7'd1);
		send_op(FUNC_INSERT, 32'h5A5A_5A5A, 7'd3);
		send_op(FUNC_INSERT, 32'h1111_1111, 7'd0);
		send_op(FUNC_INSERT, 32'h2222_2222, 7'd5);
		send_op(FUNC_READ, 32'hFFFF_FFFF, 7'd1);
		send_op(FUNC_READ, 32'h0, 7'd4);
		send_op(FUNC_READ, 32'h0, 7'd5);
		send_op(FUNC_READ, 32'h0, 7'd127);
		send_op(FUNC_REMOVE, 32'h0, 7'd2);
		send_op(FUNC_REMOVE, 32'h0, 7'd3);
		send_op(FUNC_REMOVE, 32'h0, 7'd0);
		send_op(FUNC_REMOVE, 32'h0, 7'd1);
		send_op(FUNC_READ, 32'h0, 7'd1);
		send_op(FUNC_REMOVE, 32'h0, 7'd1);
		send_op(FUNC_READ, 32'h0, 7'd0);
		wait_idle();
	endtask

	// fill to capacity, hit both full cases, then drain with long head shifts
	task automatic test_full_list();
		while (list_len < CAP)
			send_op(FUNC_APPEND, $urandom, 7'($urandom_range(127)));
		send_op(FUNC_APPEND, 32'hCAFE_F00D, 7'd0);
		send_op(FUNC_INSERT, 32'h1234_5678, 7'd1);
		send_op(FUNC_INSERT, 32'h1234_5678, 7'(CAP));
		send_op(FUNC_INSERT, 32'h1234_5678, 7'(CAP + 1));
		send_op(FUNC_READ, 32'h0, 7'(CAP));
		send_op(FUNC_READ, 32'h0, 7'(CAP + 1));
		send_op(FUNC_REMOVE, 32'h0, 7'(CAP));
		send_op(FUNC_INSERT, 32'h8765_4321, 7'd1);
		while (list_len > 0)
			send_op(FUNC_REMOVE, 32'h0, 7'd1);
		wait_idle();
	endtask

	// Length drifts up or down in phases so that both empty and full are
	// reached; positions are mostly valid, with edge and wild ones mixed in.
	task automatic test_random_mix(input int n_items, input int src_pct, input int snk_pct);
		int               k;
		int               roll;
		int               pr;
		bit               grow;
		logic [FuncW-1:0] f;
		logic [PosW-1:0]  p;
		src_idle_pct  = src_pct;
		sink_idle_pct = snk_pct;
		grow = 1'b1;
		for (k = 0; k < n_items; k++) begin
			if (list_len >= CAP && $urandom_range(7) == 0)
				grow = 1'b0;
			else if (list_len == 0 && $urandom_range(7) == 0)
				grow = 1'b1;
			else if ($urandom_range(99) < 2)
				grow = !grow;
			roll = $urandom_range(99);
			if (roll < 20)
				f = FUNC_READ;
			else if (roll < 90 && ((roll < 70) == grow))
				f = $urandom_range(1) ? FUNC_APPEND : FUNC_INSERT;
			else if (roll < 90)
				f = FUNC_REMOVE;
			else
				f = FuncW'($urandom_range(3));
			pr = $urandom_range(99);
			if (pr < 85 && list_len > 0)
				p = PosW'($urandom_range(list_len, 1));
			else if (pr < 92)
				case ($urandom_range(2))
					0: p = '0;
					1: p = PosW'(list_len);
					default: p = PosW'(list_len + 1);
				endcase
			else
				p = PosW'($urandom_range(127));
			send_op(f, $urandom, p);
		end
		wait_idle();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		src_idle_pct  = 6;
		sink_idle_pct = 46;
		test_directed_ops();
		test_full_list();
		test_random_mix(N_RANDOM, 6, 46);
		test_random_mix(N_RANDOM, 46, 6);
		test_random_mix(N_RANDOM, 0, 0);
		repeat (CAP + 8) @(posedge clk);
		$display("Sent %0d requests and checked %0d responses; peak length %0d,",
			n_sent, n_checked, peak_len);
		$display("%0d list-full and %0d bad-position statuses over three idle mixes.",
			n_full, n_range);
		if (err_cnt == 0 && expected_rsps.size() == 0)
			$display("positional_list_engine: match");
		else
			$display("positional_list_engine: mismatch");
		$finish;
	end

	initial begin
		#(20_000_000);
		$display("watchdog expired with %0d responses outstanding", expected_rsps.size());
		$display("positional_list_engine: mismatch");
		$finish;
	end

endmodule
